@@ hw/rtl/hfr_pkg.sv @@
// hfr_pkg: shared types, constants and helpers for the hex frame receiver.
// Used by the channel interfaces and every module of the block.
package hfr_pkg;

	// Default and upper bound for the per-frame digit limit
	localparam int MAX_CHARS_DEF = 12;
	localparam int MAX_CHARS_HI  = 64;

	// Message byte count carried per frame (covers the upper digit limit)
	localparam int FRAME_N_W = $clog2(MAX_CHARS_HI / 2);

	// Depth of the frame command queue between front and back
	localparam int CMD_DEPTH = 2;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START = 2'd0,
		REG_END   = 2'd1,
		REG_ACK   = 2'd2
	} reg_idx_t;

	localparam logic [7:0] START_RST = 8'h02;
	localparam logic [7:0] END_RST   = 8'h03;
	localparam logic [7:0] ACK_RST   = 8'h06;

	// Character codes for hex digits
	localparam logic [7:0] CHR_0     = 8'h30;
	localparam logic [7:0] CHR_9     = 8'h39;
	localparam logic [7:0] CHR_A     = 8'h41;
	localparam logic [7:0] CHR_F     = 8'h46;
	localparam logic [3:0] HEX_A_VAL = 4'd10;

	// Result kinds
	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_MSG = 1'b1;

	typedef enum logic {
		F_HUNT,
		F_FRAME
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ACK,
		B_FETCH,
		B_BYTE
	} back_state_t;

	// One closed frame: message byte count and the store bank it sits in
	typedef struct packed {
		logic [FRAME_N_W-1:0] n;
		logic                 bank;
	} cmd_t;

	// Back end hands a bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	// Upper-case hex digit decode; lower case is not a digit
	function automatic hex_t hex_decode(input logic [7:0] ch);
		hex_t r;
		r.ok  = 1'b0;
		r.nib = 4'd0;
		if (ch >= CHR_0 && ch <= CHR_9) begin
			r.ok  = 1'b1;
			r.nib = 4'(ch - CHR_0);
		end else if (ch >= CHR_A && ch <= CHR_F) begin
			r.ok  = 1'b1;
			r.nib = 4'(ch - CHR_A) + HEX_A_VAL;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/hfr_if.sv @@
// hfr_if: valid/ready channel interfaces of the hex frame receiver.
// Depends on hfr_pkg for the configuration index width.

// Received characters
interface hfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_char;
	modport source(output valid, output rx_char, input ready);
	modport sink(input valid, input rx_char, output ready);
endinterface

// Result items
interface hfr_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic [2:0] msg_length;
	logic       last;
	modport source(output valid, output kind, output data_byte, output msg_length,
		output last, input ready);
	modport sink(input valid, input kind, input data_byte, input msg_length,
		input last, output ready);
endinterface

// Register writes
interface hfr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hfr_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                     data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/hfr_cmd_fifo.sv @@
// hfr_cmd_fifo: small queue of closed-frame commands between front and back.
// Depends on hfr_pkg (cmd_t).
module hfr_cmd_fifo #(
	parameter int DEPTH = hfr_pkg::CMD_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hfr_pkg::cmd_t din,
	input  logic          pop,
	output hfr_pkg::cmd_t dout,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	hfr_pkg::cmd_t      entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign dout  = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ hw/rtl/hfr_front.sv @@
// hfr_front: character intake, frame hunting and hex packing into a two-bank byte store.
// Depends on hfr_pkg and hfr_if (rx channel).
module hfr_front #(
	parameter int MAX_CHARS = hfr_pkg::MAX_CHARS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	hfr_rx_if.sink                                  rx,
	input  logic [7:0]                              start_code,
	input  logic [7:0]                              end_code,
	output logic                                    push,
	output hfr_pkg::cmd_t                           cmd,
	input  logic                                    fifo_full,
	input  hfr_pkg::release_t                       rel,
	input  logic [$clog2((MAX_CHARS + 1) / 2):0]    rd_addr,
	output logic [7:0]                              rd_data
);

	localparam int STORE_DEPTH = (MAX_CHARS + 1) / 2;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_CHARS + 1);
	localparam int ADDR_W      = SLOT_W + 1;
	localparam int MEM_DEPTH   = 2 ** ADDR_W;

	hfr_pkg::front_state_t state_q, state_d;
	logic [CNT_W-1:0]      count_q;
	logic [3:0]            hi_nib_q;
	logic                  cur_bank_q;
	logic [1:0]            busy_q, busy_d;
	logic [7:0]            mem [MEM_DEPTH];
	logic [7:0]            rd_data_q;

	hfr_pkg::hex_t         hex;
	logic [CNT_W-2:0]      whole;
	logic [CNT_W-2:0]      n_w;
	logic                  acc;
	logic                  is_start;
	logic                  is_end;
	logic                  take_digit;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;

	// Decode and frame bookkeeping
	always_comb begin
		hex        = hfr_pkg::hex_decode(rx.rx_char);
		whole      = count_q[CNT_W-1:1];
		n_w        = (whole > 1) ? whole - 1'b1 : '0;
		// stall while the bank being filled is still draining, or no room for a command
		rx.ready   = (state_q == hfr_pkg::F_HUNT) || (!fifo_full && !busy_q[cur_bank_q]);
		acc        = rx.valid && rx.ready;
		is_start   = (state_q == hfr_pkg::F_HUNT) && (rx.rx_char == start_code);
		is_end     = (state_q == hfr_pkg::F_FRAME) && (rx.rx_char == end_code);
		take_digit = acc && (state_q == hfr_pkg::F_FRAME) && !is_end && hex.ok
			&& (count_q < CNT_W'(MAX_CHARS));
		push       = acc && is_end;
		cmd.n      = hfr_pkg::FRAME_N_W'(n_w);
		cmd.bank   = cur_bank_q;
		// odd digit completes a byte
		wr_en      = take_digit && count_q[0];
		wr_addr    = {cur_bank_q, count_q[SLOT_W:1]};
	end

	// Bank ownership: set when a frame with message bytes closes, cleared by the back end
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			busy_d[b] = (busy_q[b] && !(rel.valid && (rel.bank == 1'(b))))
				|| (push && (n_w != '0) && (cur_bank_q == 1'(b)));
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hfr_pkg::F_HUNT: begin
				if (acc && is_start) begin
					state_d = hfr_pkg::F_FRAME;
				end
			end
			hfr_pkg::F_FRAME: begin
				if (push) begin
					state_d = hfr_pkg::F_HUNT;
				end
			end
			default: state_d = hfr_pkg::F_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hfr_pkg::F_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// Digit count, bank pointer and bank ownership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cur_bank_q <= 1'b0;
			busy_q     <= '0;
		end else begin
			busy_q <= busy_d;
			if ((acc && is_start) || push) begin
				count_q <= '0;
			end else if (take_digit) begin
				count_q <= count_q + 1'b1;
			end
			if (push && (n_w != '0)) begin
				cur_bank_q <= !cur_bank_q;
			end
		end
	end

	// High nibble holding and byte store
	always_ff @(posedge clk) begin
		if (take_digit && !count_q[0]) begin
			hi_nib_q <= hex.nib;
		end
		if (wr_en) begin
			mem[wr_addr] <= {hi_nib_q, hex.nib};
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/hfr_back.sv @@
// hfr_back: drains frame commands and sends the acknowledge and message bytes.
// Depends on hfr_pkg and hfr_if (result channel).
module hfr_back #(
	parameter int MAX_CHARS = hfr_pkg::MAX_CHARS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	hfr_res_if.source                               res,
	input  logic [7:0]                              ack_code,
	input  logic                                    fifo_empty,
	input  hfr_pkg::cmd_t                           cmd_head,
	output logic                                    pop,
	output hfr_pkg::release_t                       rel,
	output logic [$clog2((MAX_CHARS + 1) / 2):0]    rd_addr,
	input  logic [7:0]                              rd_data
);

	localparam int SLOT_W = $clog2((MAX_CHARS + 1) / 2);

	hfr_pkg::back_state_t          state_q, state_d;
	hfr_pkg::cmd_t                 cmd_q;
	logic [hfr_pkg::FRAME_N_W-1:0] idx_q;

	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] data_q;
	logic [2:0] len_q;
	logic       last_q;

	logic slot_free;
	logic load_ack;
	logic load_byte;
	logic byte_last;

	assign slot_free = !out_valid_q || res.ready;
	assign byte_last = (idx_q == cmd_q.n - 1'b1);
	assign rd_addr   = {cmd_q.bank, idx_q[SLOT_W-1:0]};

	// Sequencer: next state and controls
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load_ack  = 1'b0;
		load_byte = 1'b0;
		rel.valid = 1'b0;
		rel.bank  = cmd_q.bank;
		unique case (state_q)
			hfr_pkg::B_IDLE: begin
				if (!fifo_empty) begin
					pop     = 1'b1;
					state_d = hfr_pkg::B_ACK;
				end
			end
			hfr_pkg::B_ACK: begin
				if (slot_free) begin
					load_ack = 1'b1;
					state_d  = (cmd_q.n == '0) ? hfr_pkg::B_IDLE : hfr_pkg::B_FETCH;
				end
			end
			// wait here while the registered store read completes
			hfr_pkg::B_FETCH: begin
				state_d = hfr_pkg::B_BYTE;
			end
			hfr_pkg::B_BYTE: begin
				if (slot_free) begin
					load_byte = 1'b1;
					if (byte_last) begin
						rel.valid = 1'b1;
						state_d   = hfr_pkg::B_IDLE;
					end else begin
						state_d = hfr_pkg::B_FETCH;
					end
				end
			end
			default: state_d = hfr_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hfr_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_ack || load_byte) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command, byte index and output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd_head;
			idx_q <= '0;
		end else if (load_byte) begin
			idx_q <= idx_q + 1'b1;
		end
		if (load_ack) begin
			kind_q <= hfr_pkg::KIND_ACK;
			data_q <= ack_code;
			len_q  <= cmd_q.n[2:0];
			last_q <= (cmd_q.n == '0);
		end else if (load_byte) begin
			kind_q <= hfr_pkg::KIND_MSG;
			data_q <= rd_data;
			len_q  <= cmd_q.n[2:0];
			last_q <= byte_last;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.kind       = kind_q;
	assign res.data_byte  = data_q;
	assign res.msg_length = len_q;
	assign res.last       = last_q;

endmodule

@@ hw/rtl/hex_frame_receiver_top.sv @@
// hex_frame_receiver_top: top level of the hex frame receiver.
// Depends on hfr_pkg, hfr_if, hfr_front, hfr_cmd_fifo and hfr_back.

// Characters are taken one per cycle; hex digits pack two per byte into a two-bank
// store. An end code queues a frame command; the output sequencer then sends the
// acknowledge and then each message byte, which goes through a registered store
// read and then the output register. Input stalls only when the command queue is
// full or when a new frame wants the bank whose bytes are still being sent.
// Configuration writes are always taken (ready is tied high) and must be issued
// while the block is idle.
module hex_frame_receiver_top #(
	parameter int MAX_CHARS = hfr_pkg::MAX_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hfr_rx_if.sink     rx,
	hfr_res_if.source  res,
	hfr_cfg_if.sink    cfg
);

	localparam int ADDR_W = $clog2((MAX_CHARS + 1) / 2) + 1;

	logic [7:0] start_code_q;
	logic [7:0] end_code_q;
	logic [7:0] ack_code_q;

	logic              push;
	logic              pop;
	logic              fifo_empty;
	logic              fifo_full;
	hfr_pkg::cmd_t     cmd_in;
	hfr_pkg::cmd_t     cmd_head;
	hfr_pkg::release_t rel;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= hfr_pkg::START_RST;
			end_code_q   <= hfr_pkg::END_RST;
			ack_code_q   <= hfr_pkg::ACK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hfr_pkg::REG_START: start_code_q <= cfg.data;
				hfr_pkg::REG_END:   end_code_q   <= cfg.data;
				hfr_pkg::REG_ACK:   ack_code_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	hfr_front #(
		.MAX_CHARS(MAX_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.start_code (start_code_q),
		.end_code   (end_code_q),
		.push       (push),
		.cmd        (cmd_in),
		.fifo_full  (fifo_full),
		.rel        (rel),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	hfr_cmd_fifo #(
		.DEPTH(hfr_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.pop    (pop),
		.dout   (cmd_head),
		.empty  (fifo_empty),
		.full   (fifo_full)
	);

	hfr_back #(
		.MAX_CHARS(MAX_CHARS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.ack_code   (ack_code_q),
		.fifo_empty (fifo_empty),
		.cmd_head   (cmd_head),
		.pop        (pop),
		.rel        (rel),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

`ifndef NO_ASSERTIONS
	// a frame command is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("command pushed into full queue");

	// the sequencer only takes a command that is there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_empty)
		else $error("command popped from empty queue");

	// a bank being handed back is never claimed again in the same cycle
	a_bank_reuse: assert property (@(posedge clk) disable iff (!arst_n)
		(rel.valid && push && (cmd_in.n != '0)) |-> (cmd_in.bank != rel.bank))
		else $error("bank reused while still draining");
`endif

endmodule
